@@ rtl/core/wsg_pkg.sv @@
// Shared constants, types and the sine table function of the waveform sample generator.
`timescale 1ns / 1ps

package wsg_pkg;

  localparam int TABLE_BITS  = 10;
  localparam int PHASE_BITS  = 32;
  localparam int TAB_N       = 1 << TABLE_BITS;
  localparam int ADDR_W      = TABLE_BITS + 1;
  localparam int ENTRY_W     = 17;
  localparam int SAMPLE_W    = 16;
  localparam int AMP_W       = 15;
  localparam int CNT_W       = 16;
  localparam int MODE_W      = 2;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int STATE_W     = PHASE_BITS + CNT_W;
  localparam int STATE_DEPTH = 1;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

  localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd4;

  localparam logic [MODE_W-1:0] MODE_SINE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SQUARE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PULSE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SILENT = 2'd3;

  localparam logic [AMP_W-1:0] AMP_RESET   = 15'd16384;
  localparam logic [CNT_W-1:0] COUNT_RESET = 16'd1024;

  // Phase of one sample and its end-of-run flag, as handed from the state stage.
  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic                  last;
  } phase_item_t;

  // Places a 32-bit turn fraction at the top of the phase word.
  function automatic logic [PHASE_BITS-1:0] align_phase(input logic [CFG_W-1:0] v);
    logic [PHASE_BITS+CFG_W-1:0] w;
    w = {v, PHASE_BITS'(0)};
    return w[PHASE_BITS+CFG_W-1 -: PHASE_BITS];
  endfunction

  // Quarter-wave sine entry in Q16, built from a Taylor series in Q30.
  function automatic logic [ENTRY_W-1:0] sine_entry(input int unsigned i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] r;
    longint      sum;
    x    = (PI_HALF_Q30 * 64'(i)) >> TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    r = (64'(sum) + 64'd8192) >> 14;
    if (i == TAB_N) begin
      r = 64'd65536;
    end
    return r[ENTRY_W-1:0];
  endfunction

endpackage

@@ rtl/core/wsg_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module wsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  generate
    if (DEPTH == 1) begin : g_single
      // A single entry needs no address decode.
      always_ff @(posedge clk) begin
        if (we) begin
          mem[0] <= wdata;
        end
        if (re) begin
          rdata <= mem[0];
        end
      end
    end else begin : g_multi
      always_ff @(posedge clk) begin
        if (we) begin
          mem[waddr] <= wdata;
        end
        if (re) begin
          rdata <= mem[raddr];
        end
      end
    end
  endgenerate

endmodule

@@ rtl/core/wsg_state.sv @@
// Run state stage: reads, updates and writes back the phase accumulator and sample index.
`timescale 1ns / 1ps

module wsg_state (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic                            restart,
  input  logic                            advance,
  input  logic [wsg_pkg::PHASE_BITS-1:0]  step,
  input  logic [wsg_pkg::PHASE_BITS-1:0]  offset,
  input  logic [wsg_pkg::CNT_W-1:0]       count,
  output logic                            valid,
  output wsg_pkg::phase_item_t            item
);

  localparam int PB = wsg_pkg::PHASE_BITS;
  localparam int CW = wsg_pkg::CNT_W;

  logic                         v1_r;
  logic                         restart_r;
  logic                         init_r;
  logic                         fwd_r;
  logic [wsg_pkg::STATE_W-1:0]  fwd_data_r;
  logic [wsg_pkg::STATE_W-1:0]  rdata;
  logic [wsg_pkg::STATE_W-1:0]  cur;
  logic [wsg_pkg::STATE_W-1:0]  wdata;
  logic [PB-1:0]                acc;
  logic [CW-1:0]                idx;
  logic [CW:0]                  idx_inc;
  logic                         last;
  logic                         we;

  wsg_ram #(
    .WIDTH (wsg_pkg::STATE_W),
    .DEPTH (wsg_pkg::STATE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (1'b0),
    .wdata (wdata),
    .re    (1'b1),
    .raddr (1'b0),
    .rdata (rdata)
  );

  // The registered read does not yet show a write made at the last edge, so that write is forwarded.
  always_comb begin
    if (!init_r) begin
      cur = '0;
    end else if (fwd_r) begin
      cur = fwd_data_r;
    end else begin
      cur = rdata;
    end
    acc = cur[wsg_pkg::STATE_W-1 -: PB];
    idx = cur[CW-1:0];
    if (restart_r) begin
      acc = '0;
      idx = '0;
    end
    idx_inc = {1'b0, idx} + (CW+1)'(1);
    last    = idx_inc >= {1'b0, count};
    if (last) begin
      wdata = '0;
    end else begin
      wdata = {acc + step, idx_inc[CW-1:0]};
    end
    we = v1_r && advance;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      init_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      if (advance) begin
        v1_r <= accept;
      end
      if (we) begin
        init_r <= 1'b1;
      end
      fwd_r <= we;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      restart_r <= restart;
    end
    if (we) begin
      fwd_data_r <= wdata;
    end
  end

  assign valid      = v1_r;
  assign item.phase = acc + offset;
  assign item.last  = last;

endmodule

@@ rtl/core/wsg_sine_rom.sv @@
// Quarter-wave sine table in Q16 with a registered read.
`timescale 1ns / 1ps

module wsg_sine_rom (
  input  logic                          clk,
  input  logic                          en,
  input  logic [wsg_pkg::ADDR_W-1:0]    addr,
  output logic [wsg_pkg::ENTRY_W-1:0]   entry
);

  logic [wsg_pkg::ENTRY_W-1:0] tab [wsg_pkg::TAB_N + 1];

  generate
    for (genvar g = 0; g <= wsg_pkg::TAB_N; g++) begin : g_tab
      assign tab[g] = wsg_pkg::sine_entry(g);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      entry <= tab[addr];
    end
  end

endmodule

@@ rtl/core/waveform_sample_generator_core.sv @@
// Top level of the waveform sample generator: configuration, pipeline and output register.
// A tick passes the state stage, then the decode, table, product and output registers.
// Throughput: one item per cycle while the output is not stalled; the state word is read,
// updated and written back for each item, the last write forwarded past the registered read.
// Reset (synchronous, active low) empties the pipeline, zeroes phase and sample index and
// restores the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module waveform_sample_generator_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [wsg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wsg_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_restart,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [wsg_pkg::SAMPLE_W-1:0] out_sample,
  output logic                             out_last
);

  localparam int PB = wsg_pkg::PHASE_BITS;
  localparam int TB = wsg_pkg::TABLE_BITS;
  localparam int SW = wsg_pkg::SAMPLE_W;
  localparam int EW = wsg_pkg::ENTRY_W;
  localparam int AW = wsg_pkg::AMP_W;

  // Configuration registers.
  logic [wsg_pkg::MODE_W-1:0] wave_mode_r;
  logic [AW-1:0]              amplitude_r;
  logic [wsg_pkg::CFG_W-1:0]  freq_step_r;
  logic [wsg_pkg::CFG_W-1:0]  phase_offset_r;
  logic [wsg_pkg::CNT_W-1:0]  sample_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_mode_r    <= wsg_pkg::MODE_SINE;
      amplitude_r    <= wsg_pkg::AMP_RESET;
      freq_step_r    <= '0;
      phase_offset_r <= '0;
      sample_count_r <= wsg_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        wsg_pkg::REG_WAVE_MODE:    wave_mode_r    <= cfg_wdata[wsg_pkg::MODE_W-1:0];
        wsg_pkg::REG_AMPLITUDE:    amplitude_r    <= cfg_wdata[AW-1:0];
        wsg_pkg::REG_FREQ_STEP:    freq_step_r    <= cfg_wdata;
        wsg_pkg::REG_PHASE_OFFSET: phase_offset_r <= cfg_wdata;
        wsg_pkg::REG_SAMPLE_COUNT: sample_count_r <= cfg_wdata[wsg_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic [PB-1:0] step;
  logic [PB-1:0] offset;

  assign step   = wsg_pkg::align_phase(freq_step_r);
  assign offset = wsg_pkg::align_phase(phase_offset_r);

  // Stage enables: a stage loads when it is empty or its content moves on.
  logic v1, v2_r, v3_r, v4_r, out_valid_r;
  logic en2, en3, en4, en5;

  assign en5      = !out_valid_r || out_ready;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign in_ready = !v1 || en2;

  wsg_pkg::phase_item_t item1;

  wsg_state u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_valid && in_ready),
    .restart (in_restart),
    .advance (in_ready),
    .step    (step),
    .offset  (offset),
    .count   (sample_count_r),
    .valid   (v1),
    .item    (item1)
  );

  // Stage 2: decode the phase into quadrant and table address, and form the other waveforms.
  wsg_pkg::phase_item_t item2_r;
  logic [1:0]              quad;
  logic [TB-1:0]           tidx;
  logic [wsg_pkg::ADDR_W-1:0] taddr;
  logic [PB-1:0]           ph_gap;
  logic [PB-1:0]           win;
  logic signed [SW-1:0]    alt;
  logic signed [SW-1:0]    amp_pos;

  always_comb begin
    quad    = item2_r.phase[PB-1 -: 2];
    tidx    = item2_r.phase[PB-3 -: TB];
    taddr   = quad[0] ? wsg_pkg::ADDR_W'(wsg_pkg::TAB_N) - {1'b0, tidx} : {1'b0, tidx};
    ph_gap  = item2_r.phase - wsg_pkg::QUARTER;
    win     = (step == '0) ? PB'(1) : step;
    amp_pos = {1'b0, amplitude_r};
    case (wave_mode_r)
      wsg_pkg::MODE_SQUARE: alt = item2_r.phase[PB-1] ? -amp_pos : amp_pos;
      wsg_pkg::MODE_PULSE:  alt = (ph_gap < win) ? amp_pos : '0;
      default:              alt = '0;
    endcase
  end

  logic [EW-1:0]        entry3;
  logic                 neg3_r, last3_r, sine3_r;
  logic signed [SW-1:0] alt3_r;

  wsg_sine_rom u_rom (
    .clk   (clk),
    .en    (en3),
    .addr  (taddr),
    .entry (entry3)
  );

  // Stage 3: scale the table entry by the amplitude.
  logic [31:0]          prod4_r;
  logic                 neg4_r, last4_r, sine4_r;
  logic signed [SW-1:0] alt4_r;

  // Stage 4: round the magnitude half up, then apply the sign; other modes pass their own sample.
  logic [32:0]          rounded;
  logic signed [SW-1:0] mag;
  logic signed [SW-1:0] sample4;

  always_comb begin
    rounded = {1'b0, prod4_r} + 33'd32768;
    mag     = rounded[SW+15:16];
    if (sine4_r) begin
      sample4 = neg4_r ? -mag : mag;
    end else begin
      sample4 = alt4_r;
    end
  end

  logic signed [SW-1:0] out_sample_r;
  logic                 out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en2) begin
        v2_r <= v1;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
      if (en5) begin
        out_valid_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      item2_r <= item1;
    end
    if (en3) begin
      neg3_r  <= quad[1];
      last3_r <= item2_r.last;
      sine3_r <= (wave_mode_r == wsg_pkg::MODE_SINE);
      alt3_r  <= alt;
    end
    if (en4) begin
      prod4_r <= 32'({17'd0, amplitude_r} * {15'd0, entry3});
      neg4_r  <= neg3_r;
      last4_r <= last3_r;
      sine4_r <= sine3_r;
      alt4_r  <= alt3_r;
    end
    if (en5) begin
      out_sample_r <= sample4;
      out_last_r   <= last4_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

endmodule

@@ rtl/core/wsg_checker.sv @@
// Port-level assertions for the waveform sample generator, bound to the top level.
`timescale 1ns / 1ps

module wsg_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [wsg_pkg::SAMPLE_W-1:0] out_sample,
  input logic                             out_last
);

  // Items accepted but not yet delivered; the pipeline holds at most five.
  logic [2:0] inflight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_last))
    else $error("result item changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 3'd0)
    else $error("result item without an accepted tick item");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 3'd5)
    else $error("more items in flight than pipeline stages");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample != 16'sh8000)
    else $error("sample outside the symmetric range");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item valid straight after reset");

endmodule

bind waveform_sample_generator_core wsg_checker u_wsg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_sample (out_sample),
  .out_last   (out_last)
);

@@ sim/tb_waveform_sample_generator_core.sv @@
// Self-checking testbench of the waveform sample generator core with its own sample predictor.
`timescale 1ns / 1ps

module tb_waveform_sample_generator_core;
  import wsg_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 160;
  localparam int RANDOM_TICKS = 1800;
  // Indices past the last register; writes to them must change nothing.
  localparam int REG_UNUSED_FIRST = 5;
  localparam int REG_UNUSED_LAST  = 7;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } sample_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]           cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_restart = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_last;

  // Predictor copy of the registers and the run state.
  logic [ENTRY_W-1:0]    sine_q16 [0:TAB_N];
  logic [MODE_W-1:0]     cur_mode   = MODE_SINE;
  logic [AMP_W-1:0]      cur_amp    = AMP_RESET;
  logic [CFG_W-1:0]      cur_step   = '0;
  logic [CFG_W-1:0]      cur_offset = '0;
  logic [CNT_W-1:0]      cur_count  = COUNT_RESET;
  logic [PHASE_BITS-1:0] acc_phase  = '0;
  logic [CNT_W-1:0]      run_index  = '0;

  logic    tick_queue[$];
  sample_t expected_samples[$];
  int      err_count = 0;
  int      results_seen = 0;
  int      idle_cycles = 0;
  int      burst_left = 0;
  int      gap_left = 0;
  int      hold_left = 0;
  int      pattern_cycle = 0;
  logic [15:0] ready_pattern = 16'hFFFF;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  waveform_sample_generator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .out_last   (out_last)
  );

  // Quarter-wave sine in Q16 from a Taylor series evaluated in Q30.
  initial begin : sine_rom_build
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    for (int i = 0; i <= TAB_N; i++) begin
      x    = (PI_HALF_Q30 * 64'(i)) >> TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 5; k++) begin
        term = ((term * x2) >> 30) / 64'(2 * k * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      sine_q16[i] = ENTRY_W'((64'(sum) + 64'd8192) >> 14);
    end
    sine_q16[TAB_N] = ENTRY_W'(65536);
  end

  function automatic logic [PHASE_BITS-1:0] turn_to_phase(input logic [CFG_W-1:0] v);
    if (PHASE_BITS >= CFG_W) begin
      return PHASE_BITS'(v) << (PHASE_BITS - CFG_W);
    end else begin
      return PHASE_BITS'(v >> (CFG_W - PHASE_BITS));
    end
  endfunction

  // Works out the sample for one tick and advances the run state.
  function automatic sample_t predict_sample(input logic restart);
    sample_t               r;
    logic [PHASE_BITS-1:0] step;
    logic [PHASE_BITS-1:0] ph;
    logic [PHASE_BITS-1:0] ph_gap;
    logic [1:0]            quad;
    logic [TABLE_BITS-1:0] slot;
    logic [ENTRY_W-1:0]    entry;
    longint                mag;
    if (restart) begin
      acc_phase = '0;
      run_index = '0;
    end
    step     = turn_to_phase(cur_step);
    ph       = acc_phase + turn_to_phase(cur_offset);
    r.sample = '0;
    case (cur_mode)
      MODE_SINE: begin
        quad  = ph[PHASE_BITS-1 -: 2];
        slot  = ph[PHASE_BITS-3 -: TABLE_BITS];
        entry = quad[0] ? sine_q16[TAB_N - int'(slot)] : sine_q16[slot];
        mag   = (longint'(cur_amp) * longint'(entry) + 64'sd32768) >>> 16;
        // The sign goes on after rounding, so halves round away from zero.
        r.sample = SAMPLE_W'(quad[1] ? -mag : mag);
      end
      MODE_SQUARE: begin
        r.sample = ph[PHASE_BITS-1] ? -SAMPLE_W'(cur_amp) : SAMPLE_W'(cur_amp);
      end
      MODE_PULSE: begin
        // Fires on the sample whose phase reaches or passes the quarter turn.
        ph_gap = ph - QUARTER;
        if (ph_gap < ((step != '0) ? step : PHASE_BITS'(1))) begin
          r.sample = SAMPLE_W'(cur_amp);
        end
      end
      default: begin
      end
    endcase
    r.last = ((CNT_W + 1)'(run_index) + 1) >= (CNT_W + 1)'(cur_count);
    if (r.last) begin
      acc_phase = '0;
      run_index = '0;
    end else begin
      acc_phase = acc_phase + step;
      run_index = run_index + 1'b1;
    end
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WAVE_MODE:    cur_mode   = value[MODE_W-1:0];
      REG_AMPLITUDE:    cur_amp    = value[AMP_W-1:0];
      REG_FREQ_STEP:    cur_step   = value;
      REG_PHASE_OFFSET: cur_offset = value;
      REG_SAMPLE_COUNT: cur_count  = value[CNT_W-1:0];
      default: begin
      end
    endcase
  endtask

  // Holds the sender back until every queued item has produced its sample.
  // The checks are made just after the edge, once the driver and monitor have settled.
  task automatic drain_samples();
    @(posedge clk);
    #1;
    while (tick_queue.size() != 0 || in_valid || expected_samples.size() != 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  task automatic push_ticks(input int n, input int restart_odds);
    for (int i = 0; i < n; i++) begin
      tick_queue.push_back(restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_turn();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      2:       return CFG_W'(1) << $urandom_range(20, CFG_W - 1);
      3:       return CFG_W'($urandom_range(1, 4096));
      4:       return 32'hFFFF_FFFF / $urandom_range(2, 64);
      5:       return {2'($urandom_range(0, 3)), 30'd0};
      default: return CFG_W'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_samples.push_back(predict_sample(in_restart));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || tick_queue.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) begin
            gap_left--;
          end
        end else begin
          in_valid   <= 1'b1;
          in_restart <= tick_queue.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : sample_monitor
    sample_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        // Twice in the run the receiver backs off long enough for the block to fill.
        if (results_seen == 350 || results_seen == 1250) begin
          hold_left = LONG_HOLD;
        end
        if (expected_samples.size() == 0) begin
          err_count++;
          $display("%0t: sample %0d last %0b arrived with none expected",
                   $time, out_sample, out_last);
        end else begin
          want = expected_samples.pop_front();
          if (out_sample !== want.sample) begin
            err_count++;
            $display("%0t: sample expected %0d got %0d", $time, want.sample, out_sample);
          end
          if (out_last !== want.last) begin
            err_count++;
            $display("%0t: last expected %0b got %0b", $time, want.last, out_last);
          end
        end
      end
      pattern_cycle++;
      if (pattern_cycle % 192 == 0) begin
        ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ready_pattern[pattern_cycle % 16];
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] wdata;
    int               ticks_sent;
    int               n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults straight out of reset.
    tick_queue.push_back(1'b0);
    tick_queue.push_back(1'b1);
    drain_samples();

    // Full-scale sine stepping an eighth of a turn, through every quadrant and back.
    write_reg(REG_WAVE_MODE, {30'h2AAA_AAAA, MODE_SINE});
    write_reg(REG_AMPLITUDE, 32'hFFFF_FFFF);
    write_reg(REG_FREQ_STEP, 32'h2000_0000);
    write_reg(REG_PHASE_OFFSET, 32'h0000_0000);
    write_reg(REG_SAMPLE_COUNT, 32'h0000_0009);
    tick_queue.push_back(1'b1);
    push_ticks(8, 0);
    drain_samples();

    // Square exactly at the half turn, with a zero count so every sample ends a run.
    write_reg(REG_WAVE_MODE, {30'd0, MODE_SQUARE});
    write_reg(REG_AMPLITUDE, 32'h0000_0001);
    write_reg(REG_PHASE_OFFSET, 32'h8000_0000);
    write_reg(REG_SAMPLE_COUNT, 32'hABCD_0000);
    push_ticks(2, 0);
    drain_samples();
    write_reg(REG_PHASE_OFFSET, 32'h4000_0000);
    push_ticks(1, 0);
    drain_samples();

    // Pulse with a zero step sitting on the quarter turn, then a real crossing.
    write_reg(REG_WAVE_MODE, {30'd0, MODE_PULSE});
    write_reg(REG_AMPLITUDE, 32'h0000_7FFF);
    write_reg(REG_FREQ_STEP, 32'h0000_0000);
    write_reg(REG_SAMPLE_COUNT, 32'h0000_0005);
    push_ticks(2, 0);
    drain_samples();
    write_reg(REG_FREQ_STEP, 32'h3000_0000);
    write_reg(REG_PHASE_OFFSET, 32'h0000_0000);
    tick_queue.push_back(1'b1);
    push_ticks(3, 0);
    drain_samples();

    // Silent mode still advances the run.
    write_reg(REG_WAVE_MODE, {30'd0, MODE_SILENT});
    tick_queue.push_back(1'b1);
    push_ticks(1, 0);
    drain_samples();

    // Count lowered below the current index: the next sample closes the run.
    write_reg(REG_WAVE_MODE, {30'd0, MODE_SINE});
    write_reg(REG_FREQ_STEP, 32'h0123_4567);
    write_reg(REG_SAMPLE_COUNT, 32'd1000);
    push_ticks(5, 0);
    drain_samples();
    write_reg(REG_SAMPLE_COUNT, 32'd2);
    push_ticks(2, 0);
    drain_samples();

    for (int i = REG_UNUSED_FIRST; i <= REG_UNUSED_LAST; i++) begin
      write_reg(CFG_IDX_W'(i), '1);
    end
    write_reg(REG_WAVE_MODE, 32'hFFFF_FFFD);
    push_ticks(1, 0);
    drain_samples();

    ticks_sent = 0;
    while (ticks_sent < RANDOM_TICKS) begin
      drain_samples();
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_WAVE_MODE, CFG_W'($urandom));
      end
      if ($urandom_range(0, 2) != 0) begin
        wdata = $urandom;
        case ($urandom_range(0, 4))
          0:       wdata[AMP_W-1:0] = '0;
          1:       wdata[AMP_W-1:0] = '1;
          default: wdata[AMP_W-1:0] = AMP_W'($urandom);
        endcase
        write_reg(REG_AMPLITUDE, wdata);
      end
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_FREQ_STEP, pick_turn());
      end
      if ($urandom_range(0, 2) == 0) begin
        write_reg(REG_PHASE_OFFSET, pick_turn());
      end
      if ($urandom_range(0, 2) != 0) begin
        wdata = $urandom;
        case ($urandom_range(0, 9))
          0:       wdata[CNT_W-1:0] = '0;
          1:       wdata[CNT_W-1:0] = '1;
          2:       wdata[CNT_W-1:0] = CNT_W'($urandom_range(1, 65535));
          default: wdata[CNT_W-1:0] = CNT_W'($urandom_range(1, 24));
        endcase
        write_reg(REG_SAMPLE_COUNT, wdata);
      end
      if ($urandom_range(0, 9) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)), $urandom);
      end
      n = $urandom_range(30, 140);
      push_ticks(n, 20);
      ticks_sent += n;
    end

    drain_samples();
    repeat (12) @(posedge clk);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ waveform_sample_generator_core.f @@
rtl/core/wsg_pkg.sv
rtl/core/wsg_ram.sv
rtl/core/wsg_state.sv
rtl/core/wsg_sine_rom.sv
rtl/core/waveform_sample_generator_core.sv
rtl/core/wsg_checker.sv
sim/tb_waveform_sample_generator_core.sv
